/* hw/rtl/bsp_point_contents_walk_core_assert.svh */
// Assertion shorthands for the point contents walk core.
// Each expects a clock named clock and an active high reset named reset.
`ifndef BSP_POINT_CONTENTS_WALK_CORE_ASSERT_SVH
`define BSP_POINT_CONTENTS_WALK_CORE_ASSERT_SVH

// Condition holds at every edge out of reset.
`define BPCW_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("bpcw: invariant violated");

// Consequence holds in the same cycle as the antecedent.
`define BPCW_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bpcw: implication violated");

// Consequence holds in the cycle after the antecedent.
`define BPCW_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bpcw: next-cycle implication violated");

`endif

/* hw/rtl/bpcw_pkg.sv */
`default_nettype none

package bpcw_pkg;

   // table sizes
   localparam int NODE_DEPTH  = 8192;
   localparam int PLANE_DEPTH = 4096;

   // walk constants
   localparam int GUARD_SLACK = 4;
   localparam int AXIAL_KINDS = 3;
   localparam int NORM_FRAC   = 14;

   // field widths
   localparam int MODE_W       = 2;
   localparam int IDX_W        = 13;
   localparam int COORD_W      = 32;
   localparam int NORM_W       = 16;
   localparam int KIND_W       = 3;
   localparam int SPLIT_W      = 12;
   localparam int CHILD_W      = 14;
   localparam int CONT_W       = 5;
   localparam int NODES_CFG_W  = 14;
   localparam int PLANES_CFG_W = 13;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 14;

   // derived widths
   localparam int NODE_AW  = $clog2(NODE_DEPTH);
   localparam int PLANE_AW = $clog2(PLANE_DEPTH);
   localparam int NODE_CW  = $clog2(NODE_DEPTH + 1);
   localparam int PLANE_CW = $clog2(PLANE_DEPTH + 1);
   localparam int W_A      = (NODE_CW > PLANE_CW) ? NODE_CW : PLANE_CW;
   localparam int W_B      = (NODES_CFG_W > CHILD_W) ? NODES_CFG_W : CHILD_W;
   localparam int W_C      = (W_A > W_B) ? W_A : W_B;
   localparam int CMP_W    = ((W_C > IDX_W) ? W_C : IDX_W) + 1;
   localparam int PROD_W   = NORM_W + COORD_W;
   localparam int ACC_W    = PROD_W + 3;

   // request modes
   localparam logic [MODE_W-1:0] MODE_PLANE_WR = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NODE_WR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QUERY    = 2'd2;

   // axial plane kinds
   localparam logic [KIND_W-1:0] KIND_AXIAL_X = 3'd0;
   localparam logic [KIND_W-1:0] KIND_AXIAL_Y = 3'd1;
   localparam logic [KIND_W-1:0] KIND_AXIAL_Z = 3'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_NODES_IN_USE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANES_IN_USE = 1'b1;

   // contents codes
   localparam logic signed [CONT_W-1:0] LEAF_EMPTY     = -5'sd1;
   localparam logic signed [CONT_W-1:0] CONTENTS_FLOOR = -5'sd16;

endpackage

`default_nettype wire

/* hw/rtl/bpcw_if.sv */
`default_nettype none

interface bpcw_req_if
   import bpcw_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [MODE_W-1:0]         mode;
   logic [IDX_W-1:0]          entry_index;
   logic signed [COORD_W-1:0] coord_x;
   logic signed [COORD_W-1:0] coord_y;
   logic signed [COORD_W-1:0] coord_z;
   logic signed [COORD_W-1:0] plane_offset;
   logic [KIND_W-1:0]         plane_kind;
   logic [SPLIT_W-1:0]        split_plane;
   logic signed [CHILD_W-1:0] front_child;
   logic signed [CHILD_W-1:0] back_child;

   modport source (output valid, mode, entry_index, coord_x, coord_y, coord_z,
                   plane_offset, plane_kind, split_plane, front_child, back_child,
                   input ready);
   modport sink (input valid, mode, entry_index, coord_x, coord_y, coord_z,
                 plane_offset, plane_kind, split_plane, front_child, back_child,
                 output ready);
endinterface

interface bpcw_rsp_if
   import bpcw_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [CONT_W-1:0] contents;
   logic                     is_answer;
   logic                     fell_back;

   modport source (output valid, contents, is_answer, fell_back, input ready);
   modport sink (input valid, contents, is_answer, fell_back, output ready);
endinterface

interface bpcw_csr_if
   import bpcw_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bsp_point_contents_walk_core.sv */
// Channel    Direction  Handshake          Payload
// req_bus    in         valid / ready      mode, entry_index, point or plane, node
// rsp_bus    out        valid / ready      contents, is_answer, fell_back
// csr_bus    in         valid / ready      reg_index, wdata
//
// A table write is accepted, then its acknowledge is handed to the output register.
// Each query level reads the node memory, then the plane memory, then subtracts the offset
// (axial) or runs three products through one multiplier (general). Reset is synchronous;
// tables are not cleared, and the user, not the block, must write entries before reads.
// A finished request waits in its own stage until the output register is free, so a stalled
// response holds the walk but never drops or repeats a result.
`default_nettype none
`include "bsp_point_contents_walk_core_assert.svh"

module bsp_point_contents_walk_core
   import bpcw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   bpcw_req_if.sink   req_bus,
   bpcw_rsp_if.source rsp_bus,
   bpcw_csr_if.sink   csr_bus
);

   typedef struct packed {
      logic [SPLIT_W-1:0]        split;
      logic signed [CHILD_W-1:0] front;
      logic signed [CHILD_W-1:0] back;
   } node_word_type;

   typedef struct packed {
      logic signed [NORM_W-1:0]  nx;
      logic signed [NORM_W-1:0]  ny;
      logic signed [NORM_W-1:0]  nz;
      logic signed [COORD_W-1:0] offset;
      logic [KIND_W-1:0]         kind;
   } plane_word_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_STEP,
      S_NODE,
      S_PLANE,
      S_MUL_Y,
      S_MUL_Z,
      S_SUM,
      S_DONE
   } state_type;

   // ---------------------------------------------------------------- tables
   node_word_type  node_mem  [NODE_DEPTH];
   plane_word_type plane_mem [PLANE_DEPTH];
   node_word_type  node_q_ff;
   plane_word_type plane_q_ff;

   logic                node_we, node_re, plane_we, plane_re;
   logic [NODE_AW-1:0]  node_waddr, node_raddr;
   logic [PLANE_AW-1:0] plane_waddr, plane_raddr;
   node_word_type       node_wdata;
   plane_word_type      plane_wdata;

   // ---------------------------------------------------------------- config
   logic [NODES_CFG_W-1:0]  nodes_in_use_ff;
   logic [PLANES_CFG_W-1:0] planes_in_use_ff;

   // ---------------------------------------------------------------- walk state
   state_type                 state_ff;
   logic [CMP_W-1:0]          ncount_ff, pcount_ff;
   logic [CMP_W-1:0]          num_ff, steps_ff;
   logic signed [COORD_W-1:0] pt_x_ff, pt_y_ff, pt_z_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [CONT_W-1:0]  res_contents_ff;
   logic                      res_answer_ff, res_fell_ff;

   logic                      rsp_valid_ff;
   logic signed [CONT_W-1:0]  rsp_contents_ff;
   logic                      rsp_answer_ff, rsp_fell_ff;

   // ---------------------------------------------------------------- combinational
   logic                      req_fire;
   logic                      out_free;
   logic [CMP_W-1:0]          idx_ext, nodes_ext, planes_ext;
   logic [CMP_W-1:0]          ncount_cur, pcount_cur;
   logic [CMP_W-1:0]          steps_in, split_ext;
   logic                      guard_hit, range_hit, bad_plane;
   logic                      axial;
   logic signed [COORD_W-1:0] axial_pick;
   logic signed [COORD_W:0]   axial_d;
   logic signed [NORM_W-1:0]  mul_a;
   logic signed [COORD_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [ACC_W-1:0]   acc_init, sum_d;
   logic                      go_back;
   logic signed [CHILD_W-1:0] next_child;
   logic                      child_leaf;
   logic signed [CONT_W-1:0]  leaf_code;

   assign req_fire    = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign out_free    = !rsp_valid_ff || rsp_bus.ready;

   // Clamp the register counts to the table depths.
   assign idx_ext    = CMP_W'(req_bus.entry_index);
   assign nodes_ext  = CMP_W'(nodes_in_use_ff);
   assign planes_ext = CMP_W'(planes_in_use_ff);
   assign ncount_cur = (nodes_ext < CMP_W'(NODE_DEPTH)) ? nodes_ext : CMP_W'(NODE_DEPTH);
   assign pcount_cur = (planes_ext < CMP_W'(PLANE_DEPTH)) ? planes_ext : CMP_W'(PLANE_DEPTH);

   // Table writes happen in the accept cycle; out-of-range indexes are dropped.
   assign node_we    = req_fire && (req_bus.mode == MODE_NODE_WR) &&
                       (idx_ext < CMP_W'(NODE_DEPTH));
   assign plane_we   = req_fire && (req_bus.mode == MODE_PLANE_WR) &&
                       (idx_ext < CMP_W'(PLANE_DEPTH));
   assign node_waddr  = idx_ext[NODE_AW-1:0];
   assign plane_waddr = idx_ext[PLANE_AW-1:0];
   assign node_wdata  = '{split: req_bus.split_plane,
                          front: req_bus.front_child,
                          back:  req_bus.back_child};
   assign plane_wdata = '{nx:     req_bus.coord_x[NORM_W-1:0],
                          ny:     req_bus.coord_y[NORM_W-1:0],
                          nz:     req_bus.coord_z[NORM_W-1:0],
                          offset: req_bus.plane_offset,
                          kind:   req_bus.plane_kind};

   // Step guard and node range check, taken before each node read.
   assign steps_in   = steps_ff + CMP_W'(1);
   assign guard_hit  = steps_in > (ncount_ff + CMP_W'(GUARD_SLACK));
   assign range_hit  = num_ff >= ncount_ff;
   assign node_re    = (state_ff == S_STEP) && !guard_hit && !range_hit;
   assign node_raddr = num_ff[NODE_AW-1:0];

   // Split plane check, taken before the plane read.
   assign split_ext   = CMP_W'(node_q_ff.split);
   assign bad_plane   = split_ext >= pcount_ff;
   assign plane_re    = (state_ff == S_NODE) && !bad_plane;
   assign plane_raddr = split_ext[PLANE_AW-1:0];

   // Axial planes: one coordinate minus the offset.
   assign axial = plane_q_ff.kind < KIND_W'(AXIAL_KINDS);

   always_comb begin
      case (plane_q_ff.kind)
         KIND_AXIAL_X: axial_pick = pt_x_ff;
         KIND_AXIAL_Y: axial_pick = pt_y_ff;
         default:      axial_pick = pt_z_ff;
      endcase
   end

   assign axial_d = (COORD_W+1)'(axial_pick) - (COORD_W+1)'(plane_q_ff.offset);

   // General planes: one shared multiplier, one component a cycle.
   always_comb begin
      case (state_ff)
         S_MUL_Y: begin
            mul_a = plane_q_ff.ny;
            mul_b = pt_y_ff;
         end
         S_MUL_Z: begin
            mul_a = plane_q_ff.nz;
            mul_b = pt_z_ff;
         end
         default: begin
            mul_a = plane_q_ff.nx;
            mul_b = pt_x_ff;
         end
      endcase
   end

   assign mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign acc_init = ACC_W'(prod_ff) - (ACC_W'(plane_q_ff.offset) <<< NORM_FRAC);
   assign sum_d    = acc_ff + ACC_W'(prod_ff);

   // Negative distance takes the back child; a negative child is a leaf.
   assign go_back    = (state_ff == S_SUM) ? sum_d[ACC_W-1] : axial_d[COORD_W];
   assign next_child = go_back ? node_q_ff.back : node_q_ff.front;
   assign child_leaf = next_child[CHILD_W-1];
   assign leaf_code  = (next_child < CHILD_W'(CONTENTS_FLOOR)) ? CONTENTS_FLOOR
                                                               : next_child[CONT_W-1:0];

   // ---------------------------------------------------------------- memories
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (node_re) begin
         node_q_ff <= node_mem[node_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (plane_we) begin
         plane_mem[plane_waddr] <= plane_wdata;
      end
      if (plane_re) begin
         plane_q_ff <= plane_mem[plane_raddr];
      end
   end

   // ---------------------------------------------------------------- registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_in_use_ff  <= '0;
         planes_in_use_ff <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_NODES_IN_USE:  nodes_in_use_ff  <= csr_bus.wdata;
            CSR_PLANES_IN_USE: planes_in_use_ff <= csr_bus.wdata[PLANES_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- walk sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Drop the response once taken; load a finished request when free.
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff    <= 1'b1;
            rsp_contents_ff <= res_contents_ff;
            rsp_answer_ff   <= res_answer_ff;
            rsp_fell_ff     <= res_fell_ff;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  pt_x_ff   <= req_bus.coord_x;
                  pt_y_ff   <= req_bus.coord_y;
                  pt_z_ff   <= req_bus.coord_z;
                  ncount_ff <= ncount_cur;
                  pcount_ff <= pcount_cur;
                  num_ff    <= idx_ext;
                  steps_ff  <= '0;
                  res_contents_ff <= LEAF_EMPTY;
                  if (req_bus.mode == MODE_QUERY) begin
                     res_answer_ff <= 1'b1;
                     if (ncount_cur == '0) begin
                        // empty node table
                        res_fell_ff <= 1'b1;
                        state_ff    <= S_DONE;
                     end else begin
                        res_fell_ff <= 1'b0;
                        state_ff    <= S_STEP;
                     end
                  end else begin
                     // table write, or an unused mode: acknowledge only
                     res_answer_ff <= 1'b0;
                     res_fell_ff   <= 1'b0;
                     state_ff      <= S_DONE;
                  end
               end
            end
            S_STEP: begin
               steps_ff <= steps_in;
               if (guard_hit || range_hit) begin
                  res_contents_ff <= LEAF_EMPTY;
                  res_fell_ff     <= 1'b1;
                  state_ff        <= S_DONE;
               end else begin
                  state_ff <= S_NODE;
               end
            end
            S_NODE: begin
               if (bad_plane) begin
                  res_contents_ff <= LEAF_EMPTY;
                  res_fell_ff     <= 1'b1;
                  state_ff        <= S_DONE;
               end else begin
                  state_ff <= S_PLANE;
               end
            end
            S_PLANE: begin
               if (axial) begin
                  if (child_leaf) begin
                     res_contents_ff <= leaf_code;
                     state_ff        <= S_DONE;
                  end else begin
                     num_ff   <= CMP_W'(next_child);
                     state_ff <= S_STEP;
                  end
               end else begin
                  prod_ff  <= mul_p;
                  state_ff <= S_MUL_Y;
               end
            end
            S_MUL_Y: begin
               prod_ff  <= mul_p;
               acc_ff   <= acc_init;
               state_ff <= S_MUL_Z;
            end
            S_MUL_Z: begin
               prod_ff  <= mul_p;
               acc_ff   <= sum_d;
               state_ff <= S_SUM;
            end
            S_SUM: begin
               if (child_leaf) begin
                  res_contents_ff <= leaf_code;
                  state_ff        <= S_DONE;
               end else begin
                  num_ff   <= CMP_W'(next_child);
                  state_ff <= S_STEP;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.contents  = rsp_contents_ff;
   assign rsp_bus.is_answer = rsp_answer_ff;
   assign rsp_bus.fell_back = rsp_fell_ff;

   // ---------------------------------------------------------------- checks
   `BPCW_ASSERT_ALWAYS(a_node_port_excl, !(node_we && node_re))
   `BPCW_ASSERT_IMPLY(a_node_in_range, state_ff == S_NODE,
                      (num_ff < ncount_ff) && (steps_ff <= ncount_ff + CMP_W'(GUARD_SLACK)))
   `BPCW_ASSERT_IMPLY(a_fell_is_empty, rsp_valid_ff && rsp_fell_ff,
                      (rsp_contents_ff == LEAF_EMPTY) && rsp_answer_ff)
   `BPCW_ASSERT_NEXT(a_query_walks,
                     req_fire && (req_bus.mode == MODE_QUERY) && (ncount_cur != '0),
                     state_ff == S_STEP)

endmodule

`default_nettype wire
